>>> src/base64_codec_custom_alphabet_macros.svh
// Assertion macros shared by the base64 codec RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BASE64_CODEC_CUSTOM_ALPHABET_MACROS_SVH
`define BASE64_CODEC_CUSTOM_ALPHABET_MACROS_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define B64CC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64cc assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define B64CC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64cc assertion failed");

`endif

>>> src/b64cc_pkg.sv
// Shared types, constants and alphabet functions of the base64 codec.
// Used by every module of the codec; depends on nothing else.
package b64cc_pkg;

    // Fixed field widths.
    localparam int ByteW   = 8;
    localparam int CountW  = 13;
    localparam int SymW    = 6;
    localparam int TdataOW = 40;

    // Default stream length bound and reset value of the output limit.
    localparam int          MaxLenDefault = 4096;
    localparam logic [12:0] LimitReset    = 13'd4096;

    // Job queue between the front and back parts.
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MODE  = 1'b0,
        CFG_LIMIT = 1'b1
    } t_cfg_idx;

    // Mode codes.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [ByteW-1:0]  value;
        logic [CountW-1:0] total;
        logic [CountW-1:0] used;
    } t_res;

    // One queued job: the one or two result items caused by an input item.
    typedef struct packed {
        logic two;
        logic has_data;
        logic last;
        t_res r0;
        t_res r1;
    } t_job;

    // Alphabet ROM: six-bit value to character code.
    function automatic logic [ByteW-1:0] char_of(input logic [SymW-1:0] v);
        logic [ByteW-1:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            char_of = 8'h61 + w;
        end else if (v < 6'd52) begin
            char_of = 8'h41 + w - 8'd26;
        end else if (v == 6'd52) begin
            char_of = 8'h2d;
        end else if (v < 6'd63) begin
            char_of = 8'h30 + w - 8'd53;
        end else begin
            char_of = 8'h2b;
        end
    endfunction

    // Reverse lookup: character code to six-bit value, zero outside the alphabet.
    function automatic logic [SymW-1:0] value_of(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] w;
        w = 8'd0;
        if (c >= 8'h61 && c <= 8'h7a) begin
            w = c - 8'h61;
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            w = c - 8'h41 + 8'd26;
        end else if (c == 8'h2d) begin
            w = 8'd52;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            w = c - 8'h30 + 8'd53;
        end else if (c == 8'h2b) begin
            w = 8'd63;
        end
        value_of = w[SymW-1:0];
    endfunction

endpackage

>>> src/b64cc_front.sv
// Front part of the base64 codec: configuration registers, stream state and
// classification of each input item into a job. Depends on b64cc_pkg.
module b64cc_front #(
    parameter int MAX_LEN = b64cc_pkg::MaxLenDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  b64cc_pkg::t_cfg_idx         i_cfg_index,
    input  logic [b64cc_pkg::CountW-1:0] i_cfg_data,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [b64cc_pkg::ByteW-1:0] i_s_tdata,
    input  logic                        i_s_tlast,
    output logic                        o_push,
    output b64cc_pkg::t_job             o_job,
    input  logic                        i_full
);
    import b64cc_pkg::*;

    localparam logic [15:0] MaxLenW = 16'(MAX_LEN);

    logic              r_mode;
    logic [CountW-1:0] r_limit;
    logic [1:0]        r_phase, n_phase;
    logic [SymW-1:0]   r_held, n_held;
    logic [CountW-1:0] r_prod, n_prod;
    logic [CountW-1:0] r_used, n_used;
    logic              r_halt, n_halt;

    logic              fire;
    logic [CountW-1:0] lim;
    logic              room0, room1;
    logic [SymW-1:0]   dec_v;
    logic [1:0]        nres;
    logic [ByteW-1:0]  val0, val1;
    logic [CountW-1:0] used0, used1;
    logic [ByteW-1:0]  b;

    assign b          = i_s_tdata;
    assign o_s_tready = !i_full;
    assign fire       = i_s_tvalid && !i_full;
    assign dec_v      = value_of(b);

    // Effective limit, clipped to the stream length bound.
    assign lim   = ({3'b000, r_limit} > MaxLenW) ? MaxLenW[CountW-1:0] : r_limit;
    assign room0 = {1'b0, r_prod} < {1'b0, lim};
    assign room1 = ({1'b0, r_prod} + 14'd1) < {1'b0, lim};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENC;
            r_limit <= LimitReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_LIMIT: r_limit <= i_cfg_data;
            endcase
        end
    end

    // Per-item encode or decode step.
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_used  = r_used;
        n_halt  = r_halt;
        nres    = 2'd0;
        val0    = '0;
        val1    = '0;
        used0   = r_used;
        used1   = r_used;
        if (!r_halt) begin
            if (r_mode == MODE_DEC) begin
                if (b == 8'd0) begin
                    n_halt = 1'b1;
                end else if (r_phase == 2'd0) begin
                    n_held  = dec_v;
                    n_phase = 2'd1;
                end else if (!room0) begin
                    n_halt = 1'b1;
                end else begin
                    unique case (r_phase)
                        2'd1:    val0 = {r_held, dec_v[5:4]};
                        2'd2:    val0 = {r_held[3:0], dec_v[5:2]};
                        default: val0 = {r_held[1:0], dec_v};
                    endcase
                    n_held  = dec_v;
                    n_phase = r_phase + 2'd1;
                    nres    = 2'd1;
                end
            end else begin
                priority if (r_phase == 2'd1) begin
                    if (!room0) begin
                        n_halt = 1'b1;
                    end else begin
                        val0    = char_of({r_held[1:0], b[7:4]});
                        used0   = r_used + 13'd1;
                        n_used  = r_used + 13'd1;
                        n_held  = {2'b00, b[3:0]};
                        n_phase = 2'd2;
                        nres    = 2'd1;
                        if (!room1) begin
                            n_halt = 1'b1;
                        end else if (i_s_tlast) begin
                            val1   = char_of({b[3:0], 2'b00});
                            used1  = r_used + 13'd2;
                            n_used = r_used + 13'd2;
                            nres   = 2'd2;
                        end
                    end
                end else if (r_phase == 2'd2) begin
                    if (!room0) begin
                        n_halt = 1'b1;
                    end else begin
                        val0    = char_of({r_held[3:0], b[7:6]});
                        used0   = r_used + 13'd1;
                        n_used  = r_used + 13'd1;
                        n_held  = '0;
                        n_phase = 2'd0;
                        nres    = 2'd1;
                        if (!room1) begin
                            n_halt = 1'b1;
                        end else begin
                            val1   = char_of(b[5:0]);
                            used1  = r_used + 13'd2;
                            n_used = r_used + 13'd2;
                            nres   = 2'd2;
                        end
                    end
                end else begin
                    // Group start; a phase left over from decoding acts as a start too.
                    if (!room1) begin
                        n_halt = 1'b1;
                    end else begin
                        val0    = char_of(b[7:2]);
                        n_held  = {4'b0000, b[1:0]};
                        n_phase = 2'd1;
                        nres    = 2'd1;
                        if (i_s_tlast) begin
                            val1   = char_of({b[1:0], 4'b0000});
                            used1  = r_used + 13'd1;
                            n_used = r_used + 13'd1;
                            nres   = 2'd2;
                        end
                    end
                end
            end
        end
        n_prod = r_prod + {11'd0, nres};
    end

    // Job built from the step; a status-only job carries the running totals.
    always_comb begin
        o_job.two      = (nres == 2'd2);
        o_job.has_data = (nres != 2'd0);
        o_job.last     = i_s_tlast;
        o_job.r0.value = val0;
        o_job.r0.total = r_prod + {12'd0, (nres != 2'd0)};
        o_job.r0.used  = (r_mode == MODE_DEC) ? '0 : used0;
        o_job.r1.value = val1;
        o_job.r1.total = r_prod + 13'd2;
        o_job.r1.used  = (r_mode == MODE_DEC) ? '0 : used1;
    end

    assign o_push = fire && ((nres != 2'd0) || i_s_tlast);

    // Stream state, cleared after the last item of each stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held  <= '0;
            r_prod  <= '0;
            r_used  <= '0;
            r_halt  <= 1'b0;
        end else if (fire) begin
            if (i_s_tlast) begin
                r_phase <= '0;
                r_held  <= '0;
                r_prod  <= '0;
                r_used  <= '0;
                r_halt  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_prod  <= n_prod;
                r_used  <= n_used;
                r_halt  <= n_halt;
            end
        end
    end

endmodule

>>> src/b64cc_fifo.sv
// Short job queue between the front and back parts of the base64 codec.
// Show-ahead register queue; depends on b64cc_pkg.
module b64cc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64cc_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output b64cc_pkg::t_job o_job,
    output logic            o_empty
);
    import b64cc_pkg::*;

    t_job              r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wr_ptr;
    logic [FifoAw-1:0] r_rd_ptr;
    logic [FifoAw:0]   r_count;

    assign o_full  = (r_count == (FifoAw+1)'(FifoDepth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> src/b64cc_back.sv
// Back part of the base64 codec (depends on b64cc_pkg): takes jobs from the queue
// and sends results out of an output register, one per cycle while tready is high.
module b64cc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  b64cc_pkg::t_job               i_job,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [b64cc_pkg::TdataOW-1:0] o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_m_tuser
);
    import b64cc_pkg::*;

    t_job r_job;
    logic r_valid;
    logic r_sub;
    logic out_fire;
    logic finish;
    t_res res;

    assign out_fire = r_valid && i_m_tready;
    assign finish   = !r_job.two || r_sub;
    assign o_pop    = !i_empty && (!r_valid || (out_fire && finish));

    // Job payload register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // Output control: valid flag and which result of the job is shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_sub   <= 1'b0;
        end else if (out_fire) begin
            if (finish) begin
                r_valid <= 1'b0;
            end else begin
                r_sub <= 1'b1;
            end
        end
    end

    // Result selection and packing.
    assign res        = r_sub ? r_job.r1 : r_job.r0;
    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_job.last && finish;
    assign o_m_tuser  = r_job.has_data;
    assign o_m_tdata  = {6'b000000, res.used, res.total, res.value};

endmodule

>>> src/base64_codec_custom_alphabet.sv
// Base64 codec with a fixed custom alphabet, unpadded: top level.
// Depends on b64cc_pkg, b64cc_front, b64cc_fifo, b64cc_back and the macro header.
//
// Usage:
//   The configuration channel (i_cfg_*) writes register 0 (mode: 0 encode,
//   1 decode) or register 1 (output limit); it is always ready. Write it only
//   while no stream is in flight.
//   The slave channel takes one item per cycle while tready is high: a byte or
//   character in tdata, tlast on the final item of a stream.
//   The master channel returns results: tdata holds the value, the running
//   result count and the encoded byte count; tuser is set on data results and
//   clear on a status-only end result; tlast marks the end of a stream.
// Flow:
//   A result passes through the job queue and then the output register. Items
//   that give at most one result flow at one per cycle while the receiver is
//   ready; an item that gives two results holds the output register until both
//   are taken, while the queue goes on taking new items.
// Reset and stalls:
//   Reset clears the stream state and the queue, sets encode mode and a limit
//   of 4096. When the receiver stalls, up to four jobs queue before tready drops.
`include "base64_codec_custom_alphabet_macros.svh"

module base64_codec_custom_alphabet #(
    parameter int MAX_LEN = b64cc_pkg::MaxLenDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  b64cc_pkg::t_cfg_idx            i_cfg_index,
    input  logic [b64cc_pkg::CountW-1:0]   i_cfg_data,
    // Input items.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [b64cc_pkg::ByteW-1:0]    i_s_tdata,   // [7:0] in_byte
    input  logic                           i_s_tlast,   // in_last
    // Result items.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [b64cc_pkg::TdataOW-1:0]  o_m_tdata,   // [7:0] out_value,
                                                        // [20:8] total_out,
                                                        // [33:21] bytes_used, zero fill
    output logic                           o_m_tlast,   // out_end
    output logic                           o_m_tuser    // [0] has_data
);
    import b64cc_pkg::*;

    logic push, pop, full, empty;
    t_job push_job, pop_job;

    assign o_cfg_ready = 1'b1;

    // Front: configuration, stream state and job building.
    b64cc_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    // Job queue.
    b64cc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    // Back: result delivery.
    b64cc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (pop_job),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // A status-only result always ends its stream and carries a zero value.
    `B64CC_ASSERT_NOW(a_status_ends, o_m_tvalid && !o_m_tuser, o_m_tlast && o_m_tdata[7:0] == 8'd0)
    // A data result always counts itself in the running total.
    `B64CC_ASSERT_NOW(a_data_counted, o_m_tvalid && o_m_tuser, o_m_tdata[20:8] != 13'd0)
    // The queue never takes a job while it is full.
    `B64CC_ASSERT_NOW(a_no_overflow, full, !push)
    // A job taken from the queue is shown at the output in the next cycle.
    `B64CC_ASSERT_NEXT(a_pop_shows, pop, o_m_tvalid)

endmodule

>>> tb/sv/base64_codec_custom_alphabet_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the unpadded base64 codec with the custom alphabet.
// Depends on b64cc_pkg and base64_codec_custom_alphabet; a built-in codec predictor
// supplies the expected result items, which are checked on the master stream.
module base64_codec_custom_alphabet_tb;
    import b64cc_pkg::*;

    localparam int MaxLen       = MaxLenDefault;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 400;
    localparam int StallLimit   = 3000;

    // One result item as the codec should deliver it.
    typedef struct packed {
        logic [7:0]  value;
        logic        has_data;
        logic        last;
        logic [12:0] total;
        logic [12:0] used;
    } codec_out_t;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index = CFG_MODE;
    logic [CountW-1:0]   i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [ByteW-1:0]    i_s_tdata   = '0;
    logic                i_s_tlast   = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [TdataOW-1:0]  o_m_tdata;
    logic                o_m_tlast;
    logic                o_m_tuser;

    base64_codec_custom_alphabet dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    string code_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-0123456789+";

    // Predictor copy of the registers and of the stream state.
    logic        mode_q     = MODE_ENC;
    logic [12:0] limit_q    = LimitReset;
    logic [1:0]  phase_q    = 2'd0;
    logic [5:0]  held_q     = 6'd0;
    logic [12:0] produced_q = 13'd0;
    logic [12:0] used_q     = 13'd0;
    logic        halted_q   = 1'b0;

    codec_out_t awaited_outputs[$];
    codec_out_t step_out[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    function automatic logic [7:0] char_for(input logic [5:0] v);
        char_for = code_chars[v];
    endfunction

    // Characters outside the alphabet map to zero.
    function automatic logic [5:0] value_for(input logic [7:0] c);
        int i;
        value_for = 6'd0;
        for (i = 0; i < 64; i++) begin
            if (code_chars[i] == c) begin
                value_for = 6'(i);
            end
        end
    endfunction

    function automatic int effective_limit();
        effective_limit = (int'(limit_q) > MaxLen) ? MaxLen : int'(limit_q);
    endfunction

    task automatic emit_result(input logic [7:0] v, input logic data);
        codec_out_t r;
        r.value    = v;
        r.has_data = data;
        r.last     = 1'b0;
        r.total    = produced_q;
        r.used     = (mode_q == MODE_DEC) ? 13'd0 : used_q;
        step_out.push_back(r);
    endtask

    task automatic emit_data(input logic [7:0] v, input logic counts_byte);
        produced_q = produced_q + 13'd1;
        if (counts_byte) begin
            used_q = used_q + 13'd1;
        end
        emit_result(v, 1'b1);
    endtask

    // Encoder: one byte gives up to two characters; the tail is flushed on the last item.
    task automatic encode_item(input logic [7:0] b, input logic last);
        int         lim;
        logic [1:0] ph;
        lim = effective_limit();
        ph  = (phase_q == 2'd3) ? 2'd0 : phase_q;
        case (ph)
            2'd0: begin
                // A group start needs room for two characters, else the lone one is dropped.
                if (int'(produced_q) + 1 >= lim) begin
                    halted_q = 1'b1;
                end else begin
                    emit_data(char_for(b[7:2]), 1'b0);
                    held_q  = {4'd0, b[1:0]};
                    phase_q = 2'd1;
                    if (last) begin
                        emit_data(char_for({held_q[1:0], 4'd0}), 1'b1);
                    end
                end
            end
            2'd1: begin
                if (int'(produced_q) >= lim) begin
                    halted_q = 1'b1;
                end else begin
                    emit_data(char_for({held_q[1:0], b[7:4]}), 1'b1);
                    held_q  = {2'd0, b[3:0]};
                    phase_q = 2'd2;
                    if (int'(produced_q) >= lim) begin
                        halted_q = 1'b1;
                    end else if (last) begin
                        emit_data(char_for({held_q[3:0], 2'd0}), 1'b1);
                    end
                end
            end
            default: begin
                if (int'(produced_q) >= lim) begin
                    halted_q = 1'b1;
                end else begin
                    emit_data(char_for({held_q[3:0], b[7:6]}), 1'b1);
                    phase_q = 2'd0;
                    held_q  = 6'd0;
                    if (int'(produced_q) >= lim) begin
                        halted_q = 1'b1;
                    end else begin
                        emit_data(char_for(b[5:0]), 1'b1);
                    end
                end
            end
        endcase
    endtask

    // Decoder: a byte for each character but the first of every group of four; NUL halts the stream.
    task automatic decode_item(input logic [7:0] c);
        logic [5:0] v;
        logic [7:0] byte_out;
        if (c == 8'h00) begin
            halted_q = 1'b1;
        end else begin
            v = value_for(c);
            if (phase_q == 2'd0) begin
                held_q  = v;
                phase_q = 2'd1;
            end else if (int'(produced_q) >= effective_limit()) begin
                halted_q = 1'b1;
            end else begin
                case (phase_q)
                    2'd1:    byte_out = {held_q[5:0], v[5:4]};
                    2'd2:    byte_out = {held_q[3:0], v[5:2]};
                    default: byte_out = {held_q[1:0], v[5:0]};
                endcase
                held_q  = v;
                phase_q = phase_q + 2'd1;
                emit_data(byte_out, 1'b0);
            end
        end
    endtask

    // Works out the result items of one accepted input item and queues them.
    task automatic codec_predict_item(input logic [7:0] b, input logic last);
        codec_out_t r;
        step_out.delete();
        if (!halted_q) begin
            if (mode_q == MODE_DEC) begin
                decode_item(b);
            end else begin
                encode_item(b, last);
            end
        end
        if (last) begin
            // A stream end without data still returns one status item.
            if (step_out.size() == 0) begin
                emit_result(8'd0, 1'b0);
            end
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
            phase_q    = 2'd0;
            held_q     = 6'd0;
            produced_q = 13'd0;
            used_q     = 13'd0;
            halted_q   = 1'b0;
        end
        foreach (step_out[i]) begin
            awaited_outputs.push_back(step_out[i]);
        end
    endtask

    // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_item(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        codec_predict_item(b, last);
    endtask

    // Sends count items taken from the top of seq down, so string literals go in order.
    task automatic send_burst(input logic [63:0] seq, input int count, input logic closes);
        int i;
        for (i = 0; i < count; i++) begin
            send_item(seq[8*(count-1-i) +: 8], closes && (i == count - 1));
        end
    endtask

    // Writes both registers back to back; only called while the codec is idle.
    task automatic configure(input logic mode, input logic [12:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= {12'd0, mode};
        do @(posedge i_clk); while (!o_cfg_ready);
        mode_q = mode;
        i_cfg_index <= CFG_LIMIT;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_q = limit;
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering items and waits until every awaited result has come out.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_outputs.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic test_encode_groups();
        send_burst(8'h00, 1, 1'b1);
        send_burst(16'hff00, 2, 1'b1);
        send_burst(24'ha55aff, 3, 1'b1);
        settle();
    endtask

    task automatic test_decode_alphabet();
        configure(MODE_DEC, 13'(MaxLen));
        send_burst("azAZ-09+", 8, 1'b1);
        // Invalid characters decode as zero; the NUL then halts the rest of the stream.
        send_burst({"!", 8'hff, 8'h00, "b"}, 4, 1'b1);
        // A lone character gives no byte, only the status item.
        send_burst("q", 1, 1'b1);
        settle();
    endtask

    task automatic test_output_limits();
        configure(MODE_ENC, 13'd0);
        send_burst(8'h41, 1, 1'b1);
        settle();
        // Room for one character only: the group start halts the stream, so no character comes out.
        configure(MODE_ENC, 13'd1);
        send_burst(16'hff01, 2, 1'b1);
        settle();
        configure(MODE_ENC, 13'd2);
        send_burst(24'h8001fe, 3, 1'b1);
        settle();
        configure(MODE_DEC, 13'd1);
        send_burst("abcd", 4, 1'b1);
        settle();
        // Largest register value, clipped to the build-time maximum.
        configure(MODE_ENC, 13'h1fff);
        send_burst(16'h7e81, 2, 1'b1);
        settle();
    endtask

    // Decode leaves phase three behind; the encoder must treat it as a group start.
    task automatic test_mode_switch_mid_stream();
        configure(MODE_DEC, 13'(MaxLen));
        send_burst("bcd", 3, 1'b0);
        settle();
        configure(MODE_ENC, 13'(MaxLen));
        send_burst(16'h3cc3, 2, 1'b1);
        settle();
    endtask

    // The receiver holds off long enough for the queue to fill and tready to drop.
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(MODE_ENC, 13'(MaxLen));
        hold_requests++;
        for (i = 0; i < 40; i++) begin
            send_item(8'($urandom_range(255)), i == 39);
        end
        settle();
    endtask

    // Batches of random streams under random register settings.
    task automatic test_random_streams(input int item_goal, input int send_pct,
                                       input int recv_pct);
        int          sent;
        int          len;
        int          i;
        int          r;
        logic [7:0]  b;
        logic [12:0] limit;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_goal) begin
            settle();
            case ($urandom_range(9))
                0:       limit = 13'd0;
                1:       limit = 13'h1fff;
                2, 3:    limit = 13'($urandom_range(1, 24));
                4:       limit = 13'($urandom_range(25, MaxLen));
                default: limit = 13'(MaxLen);
            endcase
            configure(1'($urandom_range(1)), limit);
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
                for (i = 0; i < len; i++) begin
                    if (mode_q == MODE_DEC) begin
                        // Mostly valid characters, with some noise and NUL characters.
                        r = $urandom_range(99);
                        if (r < 88) begin
                            b = code_chars[$urandom_range(63)];
                        end else if (r < 95) begin
                            b = 8'($urandom_range(255));
                        end else begin
                            b = 8'h00;
                        end
                    end else begin
                        b = 8'($urandom_range(255));
                    end
                    send_item(b, i == len - 1);
                end
                sent += len;
            end
        end
        settle();
    endtask

    // Receiver: checks each accepted result item and drives tready, with long hold-offs.
    initial begin : result_monitor
        int         hold_left;
        int         holds_taken;
        codec_out_t seen;
        codec_out_t want;
        hold_left   = 0;
        holds_taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                seen.value    = o_m_tdata[7:0];
                seen.total    = o_m_tdata[20:8];
                seen.used     = o_m_tdata[33:21];
                seen.has_data = o_m_tuser;
                seen.last     = o_m_tlast;
                if (awaited_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result item: value %02h data %0b end %0b total %0d used %0d",
                                 seen.value, seen.has_data, seen.last, seen.total, seen.used);
                    end
                end else begin
                    want = awaited_outputs.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result mismatch: expected value %02h data %0b end %0b total %0d used %0d",
                                     want.value, want.has_data, want.last, want.total, want.used);
                            $display("                 actual   value %02h data %0b end %0b total %0d used %0d",
                                     seen.value, seen.has_data, seen.last, seen.total, seen.used);
                        end
                    end
                end
            end
            if (hold_left == 0 && holds_taken != hold_requests) begin
                hold_left = HoldCycles;
                holds_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encode_groups();
        test_decode_alphabet();
        test_output_limits();
        test_mode_switch_mid_stream();
        test_backpressure();
        test_random_streams(425, 0, 0);
        test_random_streams(425, 83, 0);
        test_random_streams(425, 0, 83);
        test_random_streams(425, 34, 34);
        if (awaited_outputs.size() != 0) begin
            mismatch_count += awaited_outputs.size();
            $display("%0d expected result items never arrived", awaited_outputs.size());
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/b64cc_pkg.sv
src/b64cc_front.sv
src/b64cc_fifo.sv
src/b64cc_back.sv
src/base64_codec_custom_alphabet.sv
tb/sv/base64_codec_custom_alphabet_tb.sv
